>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define SWAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SWAT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/swat_pkg.sv
// Shared types and constants of the send window tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swat_pkg;

    // Command codes of a request
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    // Pending bitmap is stored as words of this many marks
    localparam int WORD_BITS = 16;
    localparam int BIT_W     = 4;

    // Reset value of the window limit
    localparam logic [14:0] LIMIT_RESET = 15'h7D00;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_LOOK    = 7'b0000100,
        S_MOD     = 7'b0001000,
        S_WALK_RD = 7'b0010000,
        S_WALK_EV = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

>>> rtl/swat_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/send_window_ack_tracker.sv
// Flow: a granted send passes LOOK (read the target's bitmap word), MOD (set its mark) and
// DONE; an ack in the window passes LOOK, MOD (clear its mark), then WALK_RD and WALK_EV once
// for each of the one or more 16-mark bitmap words the oldest pointer scans (one RAM read and
// one evaluation per word), then DONE. Refused sends and acks outside the window go straight
// to DONE, which waits while the result is stalled. One request in flight at a time.
// Reset: synchronous, active low; bitmap RAM then cleared one word a cycle (WINDOW_DEPTH/16 words).
`timescale 1ns / 1ps
`default_nettype none

module send_window_ack_tracker #(
    // Power of two, 16 to 32768
    parameter int WINDOW_DEPTH = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration
    input  wire logic        i_cfg_we,
    input  wire logic [14:0] i_cfg_wdata,
    // Request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_ack_id,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_granted,
    output logic [15:0]      o_assigned_id,
    output logic [15:0]      o_oldest_open,
    output logic [15:0]      o_in_flight
);

    localparam int ROWS   = WINDOW_DEPTH / swat_pkg::WORD_BITS;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [15:0] SPAN_MAX = 16'(WINDOW_DEPTH - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);

    swat_pkg::t_state r_state;
    logic [14:0]       r_limit;
    logic [15:0]       r_next;
    logic [15:0]       r_oldest;
    logic [15:0]       r_tgt;
    logic              r_grant;
    logic [ADDR_W-1:0] r_clr;

    logic              r_out_valid;
    logic              r_out_granted;
    logic [15:0]       r_out_assigned;
    logic [15:0]       r_out_oldest;
    logic [15:0]       r_out_flight;

    // Bitmap RAM ports
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [swat_pkg::WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [swat_pkg::WORD_BITS-1:0] ram_rdata;

    logic        in_take;
    logic        out_free;
    logic [15:0] span;
    logic        grant_ok;
    logic        ack_ok;

    logic [swat_pkg::BIT_W-1:0]     tgt_bit;
    logic [swat_pkg::WORD_BITS-1:0] tgt_mask;

    logic [swat_pkg::BIT_W-1:0]     walk_pos;
    logic [swat_pkg::WORD_BITS-1:0] walk_masked;
    logic                           walk_found;
    logic [swat_pkg::BIT_W-1:0]     walk_first;
    logic [swat_pkg::BIT_W:0]       walk_step;
    logic                           walk_hits_next;

    // Row of the bitmap that holds the mark of a number
    function automatic logic [ADDR_W-1:0] row_of(input logic [15:0] n);
        return ADDR_W'((n >> swat_pkg::BIT_W) & 16'(ROWS - 1));
    endfunction

    swat_ram #(
        .WIDTH (swat_pkg::WORD_BITS),
        .DEPTH (ROWS),
        .ADDR_W(ADDR_W)
    ) u_marks (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Handshake and window decisions
    assign o_in_stall = (r_state != swat_pkg::S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign span       = r_next - r_oldest;
    assign grant_ok   = (i_cmd == swat_pkg::CMD_SEND) && (span <= {1'b0, r_limit})
                        && (span < SPAN_MAX);
    assign ack_ok     = (i_cmd == swat_pkg::CMD_ACK) && ((i_ack_id - r_oldest) < span);

    // Mark of the target number inside its word
    assign tgt_bit  = r_tgt[swat_pkg::BIT_W-1:0];
    assign tgt_mask = swat_pkg::WORD_BITS'(1) << tgt_bit;

    // Walk: first pending mark at or after the oldest pointer in this word
    assign walk_pos    = r_oldest[swat_pkg::BIT_W-1:0];
    assign walk_masked = ram_rdata & ({swat_pkg::WORD_BITS{1'b1}} << walk_pos);
    assign walk_found  = |walk_masked;

    always_comb begin
        walk_first = '0;
        for (int i = swat_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (walk_masked[i]) begin
                walk_first = swat_pkg::BIT_W'(i);
            end
        end
    end

    assign walk_step = walk_found ? ({1'b0, walk_first} - {1'b0, walk_pos})
                                  : (5'(swat_pkg::WORD_BITS) - {1'b0, walk_pos});
    assign walk_hits_next = ({11'b0, walk_step} >= span);

    // RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (r_state == swat_pkg::S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == swat_pkg::S_MOD) begin
            ram_we    = 1'b1;
            ram_waddr = row_of(r_tgt);
            ram_wdata = r_grant ? (ram_rdata | tgt_mask) : (ram_rdata & ~tgt_mask);
        end
        ram_raddr = (r_state == swat_pkg::S_LOOK) ? row_of(r_tgt) : row_of(r_oldest);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= swat_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swat_pkg::S_CLEAR;
            r_next   <= 16'd1;
            r_oldest <= 16'd1;
            r_clr    <= '0;
            r_grant  <= 1'b0;
        end else begin
            unique case (r_state)
                swat_pkg::S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == LAST_ROW) begin
                        r_state <= swat_pkg::S_IDLE;
                    end
                end
                swat_pkg::S_IDLE: begin
                    if (in_take) begin
                        r_grant <= grant_ok;
                        r_tgt   <= (i_cmd == swat_pkg::CMD_SEND) ? r_next : i_ack_id;
                        r_state <= (grant_ok || ack_ok) ? swat_pkg::S_LOOK
                                                        : swat_pkg::S_DONE;
                    end
                end
                swat_pkg::S_LOOK: begin
                    r_state <= swat_pkg::S_MOD;
                end
                swat_pkg::S_MOD: begin
                    if (r_grant) begin
                        r_next  <= r_next + 16'd1;
                        r_state <= swat_pkg::S_DONE;
                    end else begin
                        r_state <= swat_pkg::S_WALK_RD;
                    end
                end
                swat_pkg::S_WALK_RD: begin
                    r_state <= (span == 16'd0) ? swat_pkg::S_DONE : swat_pkg::S_WALK_EV;
                end
                swat_pkg::S_WALK_EV: begin
                    if (walk_hits_next) begin
                        r_oldest <= r_next;
                        r_state  <= swat_pkg::S_DONE;
                    end else begin
                        r_oldest <= r_oldest + {11'b0, walk_step};
                        r_state  <= walk_found ? swat_pkg::S_DONE : swat_pkg::S_WALK_RD;
                    end
                end
                swat_pkg::S_DONE: begin
                    if (out_free) begin
                        r_state <= swat_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= swat_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == swat_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swat_pkg::S_DONE && out_free) begin
            r_out_granted  <= r_grant;
            r_out_assigned <= r_grant ? r_tgt : 16'd0;
            r_out_oldest   <= r_oldest;
            r_out_flight   <= span;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_out_granted;
    assign o_assigned_id = r_out_assigned;
    assign o_oldest_open = r_out_oldest;
    assign o_in_flight   = r_out_flight;

endmodule

`default_nettype wire

>>> rtl/swat_checker.sv
// Port-level checks of the send window tracker, bound to the top level.
// Depends on assert_macros.svh and send_window_ack_tracker.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swat_checker #(
    parameter int WINDOW_DEPTH = 32768
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_cmd,
    input wire logic [15:0] i_ack_id,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_granted,
    input wire logic [15:0] o_assigned_id,
    input wire logic [15:0] o_oldest_open,
    input wire logic [15:0] o_in_flight
);

    localparam logic [16:0] FLIGHT_END = 17'(WINDOW_DEPTH);

    logic        flight_ok;
    logic        out_refused;
    logic        out_granted;
    logic        out_held;
    logic        in_held;
    logic [48:0] out_word;
    logic [16:0] in_word;

    // Terms the assertions look at
    assign flight_ok   = ({1'b0, o_in_flight} < FLIGHT_END);
    assign out_refused = o_out_valid && !o_granted;
    assign out_granted = o_out_valid && o_granted;
    assign out_held    = o_out_valid && i_out_stall;
    assign in_held     = i_in_valid && o_in_stall;
    assign out_word    = {o_granted, o_assigned_id, o_oldest_open, o_in_flight};
    assign in_word     = {i_cmd, i_ack_id};

    // Window never grows so far that marks would alias
    `SWAT_ASSERT(a_flight_bound, o_out_valid |-> flight_ok, "in-flight past depth")

    // A refused or acknowledged request carries no number
    `SWAT_ASSERT(a_idle_id_zero, out_refused |-> (o_assigned_id == 16'd0), "number without grant")

    // A grant leaves at least its own number in flight
    `SWAT_ASSERT(a_grant_flight, out_granted |-> (o_in_flight != 16'd0), "grant, empty window")

    // A stalled result holds its payload
    `SWAT_ASSERT(a_out_hold, out_held |=> (o_out_valid && $stable(out_word)), "held result moved")

    // A stalled request holds its payload
    `SWAT_ASSERT(a_in_hold, in_held |=> (i_in_valid && $stable(in_word)), "held request moved")

endmodule

bind send_window_ack_tracker swat_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_swat_checker (.*);

`default_nettype wire
